### src/wshc_pkg.sv
// ----------------------------------------------------------------------------
// wshc_pkg: shared types and constants for the window size-hint constraint core
// Dimension width, configuration register indexes, hint flag positions and
// the packed request and response item types.
// ----------------------------------------------------------------------------
package wshc_pkg;

	localparam int unsigned DIM_BITS  = 15;
	localparam int unsigned REG_W     = 2 * DIM_BITS;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned FLAG_W    = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_SIZE,
		CFG_MAX_SIZE,
		CFG_BASE_SIZE,
		CFG_INC_SIZE,
		CFG_LOW_ASPECT,
		CFG_HIGH_ASPECT,
		CFG_HINT_FLAGS
	} cfg_idx_t;

	localparam int unsigned FLAG_MAX    = 0;
	localparam int unsigned FLAG_BASE   = 1;
	localparam int unsigned FLAG_INC    = 2;
	localparam int unsigned FLAG_ASPECT = 3;
	localparam int unsigned FLAG_NOCON  = 4;

	typedef struct packed {
		logic [DIM_BITS-1:0] req_width;
		logic [DIM_BITS-1:0] req_height;
		logic                apply_minimum;
		logic                force_constrain;
	} req_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] out_width;
		logic [DIM_BITS-1:0] out_height;
	} rsp_t;

endpackage

### src/wshc_div.sv
// ----------------------------------------------------------------------------
// wshc_div: pipelined restoring divider
// One quotient bit per register stage, NUM_W stages in all. A side-band
// vector and a valid bit travel with each item; all stages move on en.
// ----------------------------------------------------------------------------
module wshc_div #(
	parameter int unsigned NUM_W  = 2 * wshc_pkg::DIM_BITS,
	parameter int unsigned DEN_W  = wshc_pkg::DIM_BITS,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic [NUM_W-1:0]  v_s;
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  nq_s   [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0]  rem_in;
		logic [NUM_W-1:0]  nq_in;
		logic [SIDE_W-1:0] sd_in;
		logic              v_in;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign sd_in  = side_in;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign sd_in  = side_s[k-1];
			assign v_in   = v_s[k-1];
		end

		// The numerator shifts out at the top while quotient bits fill in below.
		assign trial = {rem_in, nq_in[NUM_W-1]};
		assign diff  = trial - {1'b0, den};
		assign take  = trial >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				nq_s[k]   <= {nq_in[NUM_W-2:0], take};
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[NUM_W-1];
	assign quo       = nq_s[NUM_W-1];
	assign side_out  = side_s[NUM_W-1];

endmodule

### src/window_size_hint_constrain_core.sv
// ----------------------------------------------------------------------------
// window_size_hint_constrain_core: window size-hint constraint pipeline
// Clamps a requested size to the minimum, corrects the aspect ratio, clamps
// to the maximum and snaps to resize increments above the base size.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+----------------------
//  req     | req_valid, req_stall, req        | in        | wshc_pkg::req_t
//  rsp     | rsp_valid, rsp_stall, rsp        | out       | wshc_pkg::rsp_t
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | register index, data
//          | cfg_data                         |           |
//
// One item enters per cycle; the whole pipeline holds only while the
// two-entry output queue that takes the results is full, so items keep
// entering while a result waits. Three chained banks of bit-per-stage
// dividers: two of 2*DIM_BITS stages for the aspect fits and one of DIM_BITS
// stages for the increment snap. Reset clears the valid bits, the output
// queue and the size and flag registers; increments and aspects reset to one.
module window_size_hint_constrain_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  wshc_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output wshc_pkg::rsp_t                      rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wshc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wshc_pkg::REG_W-1:0]          cfg_data
);

	localparam int unsigned D  = wshc_pkg::DIM_BITS;
	localparam int unsigned W2 = 2 * D;
	localparam logic [W2-1:0] PAIR_ONES =
		{{(D-1){1'b0}}, 1'b1, {(D-1){1'b0}}, 1'b1};

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [W2-1:0]                   min_q, max_q, base_q, inc_q, lasp_q, hasp_q;
	logic [wshc_pkg::FLAG_W-1:0]     flags_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= '0;
			base_q  <= '0;
			inc_q   <= PAIR_ONES;
			lasp_q  <= PAIR_ONES;
			hasp_q  <= PAIR_ONES;
			flags_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (wshc_pkg::cfg_idx_t'(cfg_index))
				wshc_pkg::CFG_MIN_SIZE:    min_q   <= cfg_data;
				wshc_pkg::CFG_MAX_SIZE:    max_q   <= cfg_data;
				wshc_pkg::CFG_BASE_SIZE:   base_q  <= cfg_data;
				wshc_pkg::CFG_INC_SIZE:    inc_q   <= cfg_data;
				wshc_pkg::CFG_LOW_ASPECT:  lasp_q  <= cfg_data;
				wshc_pkg::CFG_HIGH_ASPECT: hasp_q  <= cfg_data;
				wshc_pkg::CFG_HINT_FLAGS:  flags_q <= cfg_data[wshc_pkg::FLAG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic [D-1:0] min_w, min_h, max_w, max_h, lx, ly, hx, hy, inc_w, inc_h, bw, bh;
	logic         l_gt, h_gt, asp_nz;

	assign min_w  = min_q[D-1:0];
	assign min_h  = min_q[W2-1:D];
	assign max_w  = max_q[D-1:0];
	assign max_h  = max_q[W2-1:D];
	assign lx     = lasp_q[D-1:0];
	assign ly     = lasp_q[W2-1:D];
	assign hx     = hasp_q[D-1:0];
	assign hy     = hasp_q[W2-1:D];
	assign inc_w  = inc_q[D-1:0];
	assign inc_h  = inc_q[W2-1:D];
	assign bw     = flags_q[wshc_pkg::FLAG_BASE] ? base_q[D-1:0] : '0;
	assign bh     = flags_q[wshc_pkg::FLAG_BASE] ? base_q[W2-1:D] : '0;
	assign l_gt   = lx > ly;
	assign h_gt   = hx > hy;
	assign asp_nz = (lx != '0) && (ly != '0) && (hx != '0) && (hy != '0);

	// ------------------------------------------------------------------
	// Flow control: everything advances unless the output queue is full.
	// ------------------------------------------------------------------
	logic [1:0] cnt_q;
	logic       en, push, pop;

	assign en        = (cnt_q != 2'd2);
	assign req_stall = !en;

	// ------------------------------------------------------------------
	// Stage 1: minimum clamp
	// ------------------------------------------------------------------
	logic         v_s1, con_s1;
	logic [D-1:0] w_s1, h_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1   <= (req.apply_minimum && req.req_width < min_w) ? min_w : req.req_width;
			h_s1   <= (req.apply_minimum && req.req_height < min_h) ? min_h : req.req_height;
			con_s1 <= !flags_q[wshc_pkg::FLAG_NOCON] || req.force_constrain;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: cross products for the ratio tests and fit numerators
	// ------------------------------------------------------------------
	logic          v_s2, con_s2, asp_s2;
	logic [D-1:0]  w_s2, h_s2;
	logic [W2-1:0] m_wly_s2, m_hlx_s2, m_why_s2, m_hhx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2     <= w_s1;
			h_s2     <= h_s1;
			con_s2   <= con_s1;
			asp_s2   <= con_s1 && flags_q[wshc_pkg::FLAG_ASPECT] && asp_nz &&
				(w_s1 >= min_w) && (h_s1 >= min_h);
			m_wly_s2 <= W2'(w_s1) * W2'(ly);
			m_hlx_s2 <= W2'(h_s1) * W2'(lx);
			m_why_s2 <= W2'(w_s1) * W2'(hy);
			m_hhx_s2 <= W2'(h_s1) * W2'(hx);
		end
	end

	// ------------------------------------------------------------------
	// First divider bank: lowest-aspect fit and the second fit's fallback,
	// which only depends on the size entering the aspect step.
	// ------------------------------------------------------------------
	logic          v_d1a, v_d1b, v_d1c;
	logic [W2-1:0] q1a, q1b, q1c;
	logic [W2-1:0] sd1a;
	logic [1:0]    sd1b;
	logic          sd1c;

	wshc_div #(.NUM_W(W2), .DEN_W(D), .SIDE_W(W2)) u_div1a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      (l_gt ? m_wly_s2 : m_hlx_s2),
		.den      (l_gt ? lx : ly),
		.side_in  ({w_s2, h_s2}),
		.out_valid(v_d1a),
		.quo      (q1a),
		.side_out (sd1a)
	);

	wshc_div #(.NUM_W(W2), .DEN_W(D), .SIDE_W(2)) u_div1b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      (l_gt ? m_hlx_s2 : m_wly_s2),
		.den      (l_gt ? ly : lx),
		.side_in  ({con_s2, asp_s2 && (m_why_s2 > m_hhx_s2)}),
		.out_valid(v_d1b),
		.quo      (q1b),
		.side_out (sd1b)
	);

	wshc_div #(.NUM_W(W2), .DEN_W(D), .SIDE_W(1)) u_div1c (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      (h_gt ? m_hhx_s2 : m_why_s2),
		.den      (h_gt ? hy : hx),
		.side_in  (asp_s2),
		.out_valid(v_d1c),
		.quo      (q1c),
		.side_out (sd1c)
	);

	// ------------------------------------------------------------------
	// Stage 3: apply the lowest-aspect fit
	// ------------------------------------------------------------------
	logic         v_s3, con_s3, asp_s3;
	logic [D-1:0] w_s3, h_s3, lw_s3, lh_s3, qc_s3;
	logic [D-1:0] f1_w, f1_h, f1_lw, f1_lh;

	always_comb begin
		f1_lw = sd1a[W2-1:D];
		f1_lh = sd1a[D-1:0];
		f1_w  = f1_lw;
		f1_h  = f1_lh;
		if (sd1b[0]) begin
			if (l_gt) begin
				f1_h = q1a[D-1:0];
				if (f1_lh != '0 && q1a > W2'(f1_lh)) begin
					f1_h = f1_lh;
					f1_w = q1b[D-1:0];
				end
			end else begin
				f1_w = q1a[D-1:0];
				if (f1_lw != '0 && q1a > W2'(f1_lw)) begin
					f1_w = f1_lw;
					f1_h = q1b[D-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3   <= f1_w;
			h_s3   <= f1_h;
			lw_s3  <= f1_lw;
			lh_s3  <= f1_lh;
			qc_s3  <= q1c[D-1:0];
			con_s3 <= sd1b[1];
			asp_s3 <= sd1c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: products for the highest-aspect test and fit numerator
	// ------------------------------------------------------------------
	logic          v_s4, con_s4, asp_s4;
	logic [D-1:0]  w_s4, h_s4, lw_s4, lh_s4, qc_s4;
	logic [W2-1:0] p_wly_s4, p_hlx_s4, p_n_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4     <= w_s3;
			h_s4     <= h_s3;
			lw_s4    <= lw_s3;
			lh_s4    <= lh_s3;
			qc_s4    <= qc_s3;
			con_s4   <= con_s3;
			asp_s4   <= asp_s3;
			p_wly_s4 <= W2'(w_s3) * W2'(ly);
			p_hlx_s4 <= W2'(h_s3) * W2'(lx);
			p_n_s4   <= W2'(h_gt ? w_s3 : h_s3) * W2'(h_gt ? hy : hx);
		end
	end

	// ------------------------------------------------------------------
	// Second divider: highest-aspect fit
	// ------------------------------------------------------------------
	localparam int unsigned SD2_W = 5 * D + 2;

	logic             v_d2;
	logic [W2-1:0]    q2;
	logic [SD2_W-1:0] sd2;

	wshc_div #(.NUM_W(W2), .DEN_W(D), .SIDE_W(SD2_W)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (p_n_s4),
		.den      (h_gt ? hx : hy),
		.side_in  ({w_s4, h_s4, lw_s4, lh_s4, qc_s4, con_s4,
			asp_s4 && (p_wly_s4 < p_hlx_s4)}),
		.out_valid(v_d2),
		.quo      (q2),
		.side_out (sd2)
	);

	// ------------------------------------------------------------------
	// Stage 5: apply the highest-aspect fit, then the maximum clamp
	// ------------------------------------------------------------------
	logic         v_s5, con_s5;
	logic [D-1:0] w_s5, h_s5;
	logic [D-1:0] f2_w, f2_h, f2_lw, f2_lh, f2_qc;
	logic         f2_con, f2_do;

	always_comb begin
		{f2_w, f2_h, f2_lw, f2_lh, f2_qc, f2_con, f2_do} = sd2;
		if (f2_do) begin
			if (h_gt) begin
				f2_h = q2[D-1:0];
				if (f2_lh != '0 && q2 > W2'(f2_lh)) begin
					f2_h = f2_lh;
					f2_w = f2_qc;
				end
			end else begin
				f2_w = q2[D-1:0];
				if (f2_lw != '0 && q2 > W2'(f2_lw)) begin
					f2_w = f2_lw;
					f2_h = f2_qc;
				end
			end
		end
		if (f2_con && flags_q[wshc_pkg::FLAG_MAX]) begin
			if (f2_w > max_w) f2_w = max_w;
			if (f2_h > max_h) f2_h = max_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s5   <= f2_w;
			h_s5   <= f2_h;
			con_s5 <= f2_con;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: offsets above the base for the increment snap
	// ------------------------------------------------------------------
	logic         v_s6, sw_s6, sh_s6;
	logic [D-1:0] w_s6, h_s6, dw_s6, dh_s6;
	logic         snap_on;

	assign snap_on = con_s5 && flags_q[wshc_pkg::FLAG_INC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s6  <= w_s5;
			h_s6  <= h_s5;
			sw_s6 <= snap_on && (inc_w != '0) && (w_s5 > bw);
			sh_s6 <= snap_on && (inc_h != '0) && (h_s5 > bh);
			dw_s6 <= w_s5 - bw;
			dh_s6 <= h_s5 - bh;
		end
	end

	// ------------------------------------------------------------------
	// Third divider bank: whole steps above the base
	// ------------------------------------------------------------------
	logic         v_d3w, v_d3h;
	logic [D-1:0] q3w, q3h;
	logic [D:0]   sd3w, sd3h;

	wshc_div #(.NUM_W(D), .DEN_W(D), .SIDE_W(D + 1)) u_div3w (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.num      (dw_s6),
		.den      (inc_w),
		.side_in  ({w_s6, sw_s6}),
		.out_valid(v_d3w),
		.quo      (q3w),
		.side_out (sd3w)
	);

	wshc_div #(.NUM_W(D), .DEN_W(D), .SIDE_W(D + 1)) u_div3h (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.num      (dh_s6),
		.den      (inc_h),
		.side_in  ({h_s6, sh_s6}),
		.out_valid(v_d3h),
		.quo      (q3h),
		.side_out (sd3h)
	);

	// ------------------------------------------------------------------
	// Stage 7: steps times increment
	// ------------------------------------------------------------------
	logic          v_s7, sw_s7, sh_s7;
	logic [D-1:0]  w_s7, h_s7;
	logic [W2-1:0] pw_s7, ph_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_d3w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{w_s7, sw_s7} <= sd3w;
			{h_s7, sh_s7} <= sd3h;
			pw_s7         <= W2'(q3w) * W2'(inc_w);
			ph_s7         <= W2'(q3h) * W2'(inc_h);
		end
	end

	// Adding the base back cannot pass the value entering the snap.
	logic [W2-1:0]  sum_w, sum_h;
	wshc_pkg::rsp_t res;

	assign sum_w          = pw_s7 + W2'(bw);
	assign sum_h          = ph_s7 + W2'(bh);
	assign res.out_width  = sw_s7 ? sum_w[D-1:0] : w_s7;
	assign res.out_height = sh_s7 ? sum_h[D-1:0] : h_s7;

	// ------------------------------------------------------------------
	// Output queue, two entries
	// ------------------------------------------------------------------
	wshc_pkg::rsp_t buf_q [2];
	logic           wr_q, rd_q;

	assign push      = en && v_s7;
	assign rsp_valid = (cnt_q != 2'd0);
	assign pop       = rsp_valid && !rsp_stall;
	assign rsp       = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res;
		end
	end

`ifndef SYNTHESIS
	// Parallel dividers must keep their items in lockstep.
	a_div1_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(v_d1a == v_d1b) && (v_d1a == v_d1c))
		else $error("first divider bank out of step");

	a_div3_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		v_d3w == v_d3h)
		else $error("snap dividers out of step");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2))
		else $error("output queue written while full");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + 2'($past(push)) - 2'($past(pop)))
		else $error("output queue count mismatch");

	a_snap_down: assert property (@(posedge clk) disable iff (!arst_n)
		(push && sw_s7) |-> (res.out_width <= w_s7))
		else $error("snapped width grew");
`endif

endmodule
